/* rtl/additive_sine_note_synth_assert.svh */
`ifndef ADDITIVE_SINE_NOTE_SYNTH_ASSERT_SVH
`define ADDITIVE_SINE_NOTE_SYNTH_ASSERT_SVH

// cond implies prop in the same cycle
`define ASNS_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// cond implies prop in the next cycle
`define ASNS_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* rtl/asns_pkg.sv */
package asns_pkg;

   localparam int NOTE_COUNT_DEFAULT = 256;
   localparam int SINE_DEPTH_DEFAULT = 1024;
   localparam int PHASE_BITS_DEFAULT = 32;

   localparam int CMD_W    = 2;
   localparam int CHAN_W   = 8;
   localparam int NOTE_W   = 8;
   localparam int SAMPLE_W = 16;

   // 0.8 of half the 16-bit span, and the sine table peak
   localparam int SCALE_NUM = 26214;
   localparam int SINE_PEAK = 32767;
   localparam int SCALE_W   = 15;
   // quotient magnitude never exceeds SCALE_NUM
   localparam int QUOT_W    = 15;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [CMD_W-1:0] {
      CMD_NOTE_ON  = 2'd0,
      CMD_NOTE_OFF = 2'd1,
      CMD_ALL_OFF  = 2'd2,
      CMD_TICK     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_SCALE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic note_set;
      logic note_clear;
      logic all_clear;
      logic tick_start;
      logic walk_en;
      logic scale;
      logic div_step;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic walk_last;
      logic pipe_busy;
      logic div_last;
   } dp_status_type;

   // equal-tempered semitone ratios, nine decimal digits
   function automatic longint unsigned semitone_e9(int unsigned k);
      longint unsigned r;
      unique case (k)
         0:       r = 64'd1000000000;
         1:       r = 64'd1059463094;
         2:       r = 64'd1122462048;
         3:       r = 64'd1189207115;
         4:       r = 64'd1259921050;
         5:       r = 64'd1334839854;
         6:       r = 64'd1414213562;
         7:       r = 64'd1498307077;
         8:       r = 64'd1587401052;
         9:       r = 64'd1681792831;
         10:      r = 64'd1781797436;
         11:      r = 64'd1887748625;
         default: r = 64'd1000000000;
      endcase
      return r;
   endfunction

   // phase increment per sample for a note, a4 = 440 Hz at 44.1 kHz
   function automatic longint unsigned note_step(int unsigned n, int unsigned phase_bits);
      int unsigned     u;
      int unsigned     k;
      int              oct;
      int              r;
      longint unsigned num;
      longint unsigned b;
      longint unsigned c;
      longint unsigned s;
      u   = n + 3;
      oct = int'(u / 12) - 6;
      k   = u % 12;
      num = semitone_e9(k) * 64'd440;
      b   = (num << 24) / 64'd44100;
      c   = (b << 14) / 64'd1000000000;
      r   = 38 - int'(phase_bits) - oct;
      if (r > 0) begin
         s = (c + (64'd1 << (r - 1))) >> r;
      end else if (r == 0) begin
         s = c;
      end else begin
         s = c << (-r);
      end
      return s & ((64'd1 << phase_bits) - 64'd1);
   endfunction

   // one sine table entry, quarter wave by q30 taylor series
   function automatic logic signed [SAMPLE_W-1:0] sine_entry(int unsigned i,
                                                             int unsigned depth_log2);
      longint unsigned m;
      longint unsigned q;
      longint unsigned rem;
      longint unsigned x;
      longint unsigned term;
      longint unsigned v;
      longint unsigned r;
      longint          acc;
      m   = 64'(i) << 2;
      q   = m >> depth_log2;
      rem = m & ((64'd1 << depth_log2) - 64'd1);
      if (q[0]) begin
         rem = (64'd1 << depth_log2) - rem;
      end
      x    = (HALF_PI_Q30 * rem) >> depth_log2;
      term = x;
      acc  = signed'(x);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd6;
      acc  = acc - signed'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd20;
      acc  = acc + signed'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd42;
      acc  = acc - signed'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd72;
      acc  = acc + signed'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd110;
      acc  = acc - signed'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd156;
      acc  = acc + signed'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd210;
      acc  = acc - signed'(term);
      v = (acc < 0) ? 64'd0 : unsigned'(acc);
      r = (v * 64'd32767 + (64'd1 << 29)) >> 30;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return (q >= 64'd2) ? SAMPLE_W'(-signed'(r)) : SAMPLE_W'(signed'(r));
   endfunction

endpackage

/* rtl/asns_if.sv */
interface asns_req_if;
   logic                          valid;
   logic                          ready;
   logic [asns_pkg::CMD_W-1:0]    cmd;
   logic [asns_pkg::CHAN_W-1:0]   event_channel;
   logic [asns_pkg::NOTE_W-1:0]   note_number;

   modport source (output valid, cmd, event_channel, note_number, input ready);
   modport sink   (input valid, cmd, event_channel, note_number, output ready);
endinterface

interface asns_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [asns_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

interface asns_csr_if;
   logic                        valid;
   logic                        ready;
   logic [asns_pkg::CHAN_W-1:0] listen_channel;

   modport source (output valid, listen_channel, input ready);
   modport sink   (input valid, listen_channel, output ready);
endinterface

/* rtl/asns_ctrl.sv */
module asns_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [asns_pkg::CMD_W-1:0]  req_cmd,
   output logic                        req_ready,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output asns_pkg::ctrl_cmd_type      ctrl,
   input  asns_pkg::dp_status_type     status
);

   asns_pkg::state_type state_ff;
   asns_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                accept;
   logic                out_free;
   asns_pkg::cmd_type   cmd;

   assign cmd       = asns_pkg::cmd_type'(req_cmd);
   assign req_ready = (state_ff == asns_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         asns_pkg::ST_IDLE: begin
            if (accept && (cmd == asns_pkg::CMD_TICK)) begin
               state_in = asns_pkg::ST_WALK;
            end
         end
         asns_pkg::ST_WALK: begin
            if (status.walk_last) begin
               state_in = asns_pkg::ST_DRAIN;
            end
         end
         asns_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = asns_pkg::ST_SCALE;
            end
         end
         asns_pkg::ST_SCALE: begin
            state_in = asns_pkg::ST_DIVIDE;
         end
         asns_pkg::ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = asns_pkg::ST_EMIT;
            end
         end
         asns_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = asns_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = asns_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl            = '0;
      ctrl.note_set   = accept && (cmd == asns_pkg::CMD_NOTE_ON);
      ctrl.note_clear = accept && (cmd == asns_pkg::CMD_NOTE_OFF);
      ctrl.all_clear  = accept && (cmd == asns_pkg::CMD_ALL_OFF);
      ctrl.tick_start = accept && (cmd == asns_pkg::CMD_TICK);
      unique case (state_ff)
         asns_pkg::ST_WALK:   ctrl.walk_en  = 1'b1;
         asns_pkg::ST_SCALE:  ctrl.scale    = 1'b1;
         asns_pkg::ST_DIVIDE: ctrl.div_step = 1'b1;
         asns_pkg::ST_EMIT:   ctrl.load_out = out_free;
         default:             ctrl.walk_en  = 1'b0;
      endcase
   end

   always_comb begin
      priority if (ctrl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asns_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/asns_datapath.sv */
module asns_datapath #(
   parameter int NOTE_COUNT       = asns_pkg::NOTE_COUNT_DEFAULT,
   parameter int SINE_TABLE_DEPTH = asns_pkg::SINE_DEPTH_DEFAULT,
   parameter int PHASE_BITS       = asns_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  asns_pkg::ctrl_cmd_type               ctrl,
   output asns_pkg::dp_status_type              status,
   input  logic                                 csr_write,
   input  logic [asns_pkg::CHAN_W-1:0]          csr_listen_channel,
   input  logic [asns_pkg::CHAN_W-1:0]          req_event_channel,
   input  logic [asns_pkg::NOTE_W-1:0]          req_note_number,
   output logic signed [asns_pkg::SAMPLE_W-1:0] rsp_sample
);

   localparam int NOTE_AW  = $clog2(NOTE_COUNT);
   localparam int SINE_AW  = $clog2(SINE_TABLE_DEPTH);
   localparam int CNT_W    = $clog2(NOTE_COUNT + 1);
   localparam int MAG_W    = asns_pkg::SAMPLE_W - 1 + NOTE_AW;
   localparam int SUM_W    = MAG_W + 1;
   localparam int NUM_W    = MAG_W + asns_pkg::SCALE_W;
   localparam int DEN_W    = CNT_W + asns_pkg::SCALE_W;
   localparam int TRIAL_W  = DEN_W + asns_pkg::QUOT_W - 1;
   localparam int CMP_W    = (NUM_W > TRIAL_W) ? NUM_W : TRIAL_W;
   localparam int BIT_W    = $clog2(asns_pkg::QUOT_W);
   localparam int SAMPLE_W = asns_pkg::SAMPLE_W;
   localparam logic [asns_pkg::NOTE_W:0] NOTE_LIMIT = (asns_pkg::NOTE_W + 1)'(NOTE_COUNT);
   localparam logic [NOTE_AW-1:0] LAST_NOTE = NOTE_AW'(NOTE_COUNT - 1);
   localparam logic [BIT_W-1:0]   TOP_BIT   = BIT_W'(asns_pkg::QUOT_W - 1);

   // constant tables
   logic        [PHASE_BITS-1:0] step_rom [NOTE_COUNT];
   logic signed [SAMPLE_W-1:0]   sine_rom [SINE_TABLE_DEPTH];

   for (genvar gn = 0; gn < NOTE_COUNT; gn++) begin : g_step
      localparam logic [PHASE_BITS-1:0] STEP = PHASE_BITS'(asns_pkg::note_step(gn, PHASE_BITS));
      assign step_rom[gn] = STEP;
   end

   for (genvar gs = 0; gs < SINE_TABLE_DEPTH; gs++) begin : g_sine
      localparam logic signed [SAMPLE_W-1:0] ENTRY = asns_pkg::sine_entry(gs, SINE_AW);
      assign sine_rom[gs] = ENTRY;
   end

   logic [asns_pkg::CHAN_W-1:0] listen_ff;
   logic [asns_pkg::CHAN_W-1:0] listen_in;
   logic [NOTE_COUNT-1:0]       note_active_ff;
   logic [NOTE_COUNT-1:0]       note_active_in;
   logic [PHASE_BITS-1:0]       sample_count_ff;
   logic [PHASE_BITS-1:0]       sample_count_in;
   logic [NOTE_AW-1:0]          walk_idx_ff;
   logic [NOTE_AW-1:0]          walk_idx_in;
   logic                        v1_ff, v2_ff, v3_ff;
   logic                        v1_in, v2_in, v3_in;
   logic                        act1_ff, act2_ff, act3_ff;
   logic                        act1_in, act2_in, act3_in;
   logic [PHASE_BITS-1:0]       step_rd_ff;
   logic [PHASE_BITS-1:0]       phase_ff;
   logic [PHASE_BITS-1:0]       phase_in;
   logic [SINE_AW-1:0]          sine_addr;
   logic signed [SAMPLE_W-1:0]  sine_rd_ff;
   logic signed [SUM_W-1:0]     sum_ff;
   logic signed [SUM_W-1:0]     sum_in;
   logic [CNT_W-1:0]            cnt_ff;
   logic [CNT_W-1:0]            cnt_in;
   logic [MAG_W-1:0]            sum_mag;
   logic [NUM_W-1:0]            scaled;
   logic [CMP_W-1:0]            trial;
   logic [CMP_W-1:0]            rem_ff;
   logic [CMP_W-1:0]            rem_in;
   logic [DEN_W-1:0]            den_ff;
   logic [DEN_W-1:0]            den_in;
   logic [asns_pkg::QUOT_W-1:0] quot_ff;
   logic [asns_pkg::QUOT_W-1:0] quot_in;
   logic [BIT_W-1:0]            bit_ff;
   logic [BIT_W-1:0]            bit_in;
   logic                        neg_ff, neg_in;
   logic                        zero_ff, zero_in;
   logic signed [SAMPLE_W-1:0]  sample_ff;
   logic signed [SAMPLE_W-1:0]  sample_in;
   logic                        note_hit;

   // note bits, channel register and sample counter
   always_comb begin
      note_hit = (req_event_channel == listen_ff) && ({1'b0, req_note_number} < NOTE_LIMIT);
      note_active_in = note_active_ff;
      priority if (ctrl.all_clear) begin
         note_active_in = '0;
      end else if (note_hit && ctrl.note_set) begin
         note_active_in[req_note_number[NOTE_AW-1:0]] = 1'b1;
      end else if (note_hit && ctrl.note_clear) begin
         note_active_in[req_note_number[NOTE_AW-1:0]] = 1'b0;
      end else begin
         note_active_in = note_active_ff;
      end
      listen_in = csr_write ? csr_listen_channel : listen_ff;
      sample_count_in = ctrl.load_out ? sample_count_ff + 1'b1 : sample_count_ff;
   end

   // note walk: step rom, phase multiply, sine rom, accumulate
   always_comb begin
      priority if (ctrl.tick_start) begin
         walk_idx_in = '0;
      end else if (ctrl.walk_en) begin
         walk_idx_in = walk_idx_ff + 1'b1;
      end else begin
         walk_idx_in = walk_idx_ff;
      end
      v1_in    = ctrl.walk_en;
      act1_in  = ctrl.walk_en && note_active_ff[walk_idx_ff];
      v2_in    = v1_ff;
      act2_in  = act1_ff;
      v3_in    = v2_ff;
      act3_in  = act2_ff;
      phase_in = sample_count_ff * step_rd_ff;
      sine_addr = phase_ff[PHASE_BITS-1 -: SINE_AW];
      priority if (ctrl.tick_start) begin
         sum_in = '0;
         cnt_in = '0;
      end else if (act3_ff) begin
         sum_in = sum_ff + SUM_W'(sine_rd_ff);
         cnt_in = cnt_ff + 1'b1;
      end else begin
         sum_in = sum_ff;
         cnt_in = cnt_ff;
      end
   end

   // scaling and restoring divide, one quotient bit per cycle
   always_comb begin
      sum_mag = sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);
      scaled  = NUM_W'(sum_mag) * NUM_W'(asns_pkg::SCALE_NUM);
      trial   = CMP_W'(den_ff) << bit_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      bit_in  = bit_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      priority if (ctrl.scale) begin
         rem_in  = CMP_W'(scaled);
         den_in  = DEN_W'(cnt_ff) * DEN_W'(asns_pkg::SINE_PEAK);
         quot_in = '0;
         bit_in  = TOP_BIT;
         neg_in  = sum_ff[SUM_W-1];
         zero_in = (cnt_ff == '0);
      end else if (ctrl.div_step) begin
         if (rem_ff >= trial) begin
            rem_in          = rem_ff - trial;
            quot_in[bit_ff] = 1'b1;
         end
         bit_in = bit_ff - 1'b1;
      end else begin
         bit_in = bit_ff;
      end
      // no active note gives silence
      priority if (zero_ff) begin
         sample_in = '0;
      end else if (neg_ff) begin
         sample_in = -SAMPLE_W'(quot_ff);
      end else begin
         sample_in = SAMPLE_W'(quot_ff);
      end
   end

   assign status.walk_last = (walk_idx_ff == LAST_NOTE);
   assign status.pipe_busy = v1_ff || v2_ff || v3_ff;
   assign status.div_last  = (bit_ff == '0);
   assign rsp_sample       = sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff       <= '0;
         note_active_ff  <= '0;
         sample_count_ff <= '0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         v3_ff           <= 1'b0;
         act1_ff         <= 1'b0;
         act2_ff         <= 1'b0;
         act3_ff         <= 1'b0;
      end else begin
         listen_ff       <= listen_in;
         note_active_ff  <= note_active_in;
         sample_count_ff <= sample_count_in;
         v1_ff           <= v1_in;
         v2_ff           <= v2_in;
         v3_ff           <= v3_in;
         act1_ff         <= act1_in;
         act2_ff         <= act2_in;
         act3_ff         <= act3_in;
      end
   end

   always_ff @(posedge clock) begin
      step_rd_ff <= step_rom[walk_idx_ff];
      sine_rd_ff <= sine_rom[sine_addr];
   end

   always_ff @(posedge clock) begin
      walk_idx_ff <= walk_idx_in;
      phase_ff    <= phase_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quot_ff     <= quot_in;
      bit_ff      <= bit_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      if (ctrl.load_out) begin
         sample_ff <= sample_in;
      end
   end

endmodule

/* rtl/additive_sine_note_synth.sv */
// Polyphonic sine tone generator. Note-on and note-off words set or clear one
// of NOTE_COUNT note bits when their channel equals the listen channel
// register; an all-off word clears every bit. Each of these gives no result.
// A tick word walks all NOTE_COUNT notes one per cycle through the
// phase-step rom, a multiplier and the registered sine rom, sums the active
// ones, scales the sum by 0.8 full scale over the active count with a
// restoring divider, and returns one mono sample (0 with no note on) before
// advancing the sample counter. The result sits in an output register, so note
// words are taken while it waits; a later tick finishes only once it is free.
// Writing the listen channel leaves the note bits as they are; issue all-off
// after it. Reset clears all notes, the sample counter and the channel.
module additive_sine_note_synth #(
   parameter int NOTE_COUNT       = asns_pkg::NOTE_COUNT_DEFAULT,
   parameter int SINE_TABLE_DEPTH = asns_pkg::SINE_DEPTH_DEFAULT,
   parameter int PHASE_BITS       = asns_pkg::PHASE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   asns_req_if.sink   req_chan,
   asns_rsp_if.source rsp_chan,
   asns_csr_if.sink   csr_chan
);

   asns_pkg::ctrl_cmd_type  ctrl;
   asns_pkg::dp_status_type status;
   logic                    csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   asns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .ctrl      (ctrl),
      .status    (status)
   );

   asns_datapath #(
      .NOTE_COUNT       (NOTE_COUNT),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .PHASE_BITS       (PHASE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .status             (status),
      .csr_write          (csr_write),
      .csr_listen_channel (csr_chan.listen_channel),
      .req_event_channel  (req_chan.event_channel),
      .req_note_number    (req_chan.note_number),
      .rsp_sample         (rsp_chan.sample)
   );

endmodule

/* rtl/asns_checker.sv */
`include "additive_sine_note_synth_assert.svh"

module asns_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [asns_pkg::CMD_W-1:0]           req_cmd,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [asns_pkg::SAMPLE_W-1:0] rsp_sample
);

   `ASNS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result word dropped")
   `ASNS_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_sample), "stalled word changed")
   `ASNS_ASSERT_NOW(a_sample_range, rsp_valid, (rsp_sample <= 16'sd26214) && (rsp_sample >= -16'sd26214), "sample beyond 0.8 full scale")
   `ASNS_ASSERT_NEXT(a_tick_busy, req_valid && req_ready && (req_cmd == asns_pkg::CMD_TICK), !req_ready, "input not stalled after tick")
   `ASNS_ASSERT_NOW(a_rsp_after_work, $rose(rsp_valid), !$past(req_ready), "result appeared while idle")

endmodule

bind additive_sine_note_synth asns_checker u_asns_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_cmd    (req_chan.cmd),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_sample (rsp_chan.sample)
);
